// ----- hw/rtl/daily_window_pin_scheduler_unit_assert.svh -----
`ifndef DAILY_WINDOW_PIN_SCHEDULER_UNIT_ASSERT_SVH
`define DAILY_WINDOW_PIN_SCHEDULER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DWPS_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DWPS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dwps_pkg.sv -----
package dwps_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int MIN_PER_HOUR    = 60;
    localparam int SEC_PER_MIN     = 60;

    localparam int REQW = 2;
    localparam int SECW = 17;
    localparam int HRW  = 5;
    localparam int MNW  = 6;
    localparam int PINW = 6;
    localparam int IDXW = 4;
    localparam int STW  = 2;
    localparam int MINW = 11;
    localparam int EVW  = $clog2(MAX_RESULTS + 1);

    localparam logic [REQW-1:0] REQ_TICK = 2'd0;
    localparam logic [REQW-1:0] REQ_ADD  = 2'd1;
    localparam logic [REQW-1:0] REQ_DEL  = 2'd2;

    localparam logic [STW-1:0] STAT_OK      = 2'd0;
    localparam logic [STW-1:0] STAT_COVERED = 2'd1;
    localparam logic [STW-1:0] STAT_FULL    = 2'd2;
    localparam logic [STW-1:0] STAT_BADIDX  = 2'd3;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [MINW-1:0] start_min;
        logic [MINW-1:0] end_min;
        logic [PINW-1:0] pin;
        logic            active;
    } t_entry;

    typedef struct packed {
        logic act;
        logic cov;
    } t_probe;

    typedef struct packed {
        logic            kind;
        logic [PINW-1:0] pin;
        logic            level;
        logic [STW-1:0]  status;
        logic            last;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/daily_window_pin_scheduler_unit.sv -----
// Daily window pin scheduler. The window table is a ring of MAX_WINDOWS cells that rotates
// by one entry per cycle past a single compare unit at its head, except while a result is
// waiting on a full output register. A tick or an add walks the whole ring; a delete does
// the same walk and closes the gap left by the removed entry on the way. A delete with a bad
// index skips the walk. A transaction stalls while it has a result to emit and the output
// holds a result that is not yet taken. A new transaction is accepted only after the
// previous one has delivered its last result to the output register.
module daily_window_pin_scheduler_unit #(
    parameter int MAX_WINDOWS = dwps_pkg::MAX_WINDOWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dwps_pkg::REQW-1:0]  i_req_type,
    input  logic [dwps_pkg::SECW-1:0]  i_now_second,
    input  logic [dwps_pkg::HRW-1:0]   i_start_hour,
    input  logic [dwps_pkg::MNW-1:0]   i_start_minute,
    input  logic [dwps_pkg::HRW-1:0]   i_end_hour,
    input  logic [dwps_pkg::MNW-1:0]   i_end_minute,
    input  logic [dwps_pkg::PINW-1:0]  i_pin,
    input  logic [dwps_pkg::IDXW-1:0]  i_entry_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [dwps_pkg::PINW-1:0]  o_out_pin,
    output logic                       o_level,
    output logic [dwps_pkg::STW-1:0]   o_status,
    output logic                       o_last
);
    import dwps_pkg::*;

    `include "daily_window_pin_scheduler_unit_assert.svh"

    localparam int CW   = $clog2(MAX_WINDOWS + 1);
    localparam int IW   = (CW > IDXW) ? CW : IDXW;
    localparam int NEXT = (MAX_WINDOWS > 1) ? 1 : 0;
    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_WINDOWS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WINDOWS);
    localparam logic [EVW-1:0] EV_LIMIT = EVW'(MAX_RESULTS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_step, n_step;
    logic [EVW-1:0]  r_nev, n_nev;
    logic            r_cov, n_cov;
    logic            r_pend_valid, n_pend_valid;
    logic [PINW-1:0] r_pend_pin, n_pend_pin;
    logic            r_pend_level, n_pend_level;
    logic            r_o_valid;
    t_result         r_res;

    logic [REQW-1:0] r_req;
    logic [SECW-1:0] r_now;
    logic [MINW-1:0] r_ns;
    logic [MINW-1:0] r_ne;
    logic [PINW-1:0] r_pin;
    logic [IDXW-1:0] r_idx;
    logic            r_bad;

    t_entry  w_cell [MAX_WINDOWS];
    t_entry  w_feed;
    t_entry  w_new;
    t_probe  w_probe;
    logic    w_shift;
    logic    w_emit;
    t_result w_res;
    logic    w_out_free;
    logic    w_adv;
    logic    w_in_range;
    logic    w_change;
    logic    w_accept;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOWS; g++) begin : g_ring
            if (g == MAX_WINDOWS - 1) begin : g_tail
                dwps_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_entry (w_feed),
                    .o_entry (w_cell[g])
                );
            end else begin : g_body
                dwps_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_entry (w_cell[g+1]),
                    .o_entry (w_cell[g])
                );
            end
        end
    endgenerate

    dwps_head u_head (
        .i_entry (w_cell[0]),
        .i_now   (r_now),
        .i_ns    (r_ns),
        .i_ne    (r_ne),
        .i_pin   (r_pin),
        .o_probe (w_probe)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_in_range = (r_step < r_count);
    assign w_change   = w_in_range && (r_nev < EV_LIMIT) && (w_probe.act != w_cell[0].active);

    always_comb begin
        w_new.start_min = r_ns;
        w_new.end_min   = r_ne;
        w_new.pin       = r_pin;
        w_new.active    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_now <= i_now_second;
            r_ns  <= MINW'(i_start_hour) * MINW'(MIN_PER_HOUR) + MINW'(i_start_minute);
            r_ne  <= MINW'(i_end_hour) * MINW'(MIN_PER_HOUR) + MINW'(i_end_minute);
            r_pin <= i_pin;
            r_idx <= i_entry_index;
            r_bad <= (IW'(i_entry_index) >= IW'(r_count));
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_nev        = r_nev;
        n_cov        = r_cov;
        n_pend_valid = r_pend_valid;
        n_pend_pin   = r_pend_pin;
        n_pend_level = r_pend_level;
        w_feed       = w_cell[0];
        w_emit       = 1'b0;
        w_res.kind   = KIND_STATUS;
        w_res.pin    = '0;
        w_res.level  = 1'b0;
        w_res.status = STAT_OK;
        w_res.last   = 1'b1;
        w_adv        = 1'b0;
        w_shift      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_step       = '0;
                    n_nev        = '0;
                    n_cov        = 1'b0;
                    n_pend_valid = 1'b0;
                    case (i_req_type)
                        REQ_TICK: n_state = ST_WALK;
                        REQ_ADD:  n_state = ST_WALK;
                        REQ_DEL: begin
                            if (IW'(i_entry_index) >= IW'(r_count)) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_WALK;
                            end
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                case (r_req)
                    REQ_TICK: begin
                        if (w_change && r_pend_valid) begin
                            w_emit       = 1'b1;
                            w_res.kind   = KIND_EVENT;
                            w_res.pin    = r_pend_pin;
                            w_res.level  = r_pend_level;
                            w_res.last   = 1'b0;
                        end
                        w_adv = !w_emit || w_out_free;
                        if (w_change) begin
                            w_feed.active = w_probe.act;
                            if (w_adv) begin
                                n_pend_valid = 1'b1;
                                n_pend_pin   = w_cell[0].pin;
                                n_pend_level = w_probe.act;
                                n_nev        = r_nev + EVW'(1);
                            end
                        end
                    end
                    REQ_ADD: begin
                        w_adv = 1'b1;
                        if (w_in_range && w_probe.cov) begin
                            n_cov = 1'b1;
                        end
                        if ((r_step == r_count) && !r_cov) begin
                            w_feed = w_new;
                        end
                    end
                    default: begin
                        if ((IW'(r_step) == IW'(r_idx)) && w_cell[0].active) begin
                            w_emit      = 1'b1;
                            w_res.kind  = KIND_EVENT;
                            w_res.pin   = w_cell[0].pin;
                            w_res.level = 1'b0;
                            w_res.last  = 1'b0;
                        end
                        w_adv = !w_emit || w_out_free;
                        if (IW'(r_step) >= IW'(r_idx)) begin
                            w_feed = w_cell[NEXT];
                        end
                    end
                endcase
                w_shift = w_adv;
                if (w_adv) begin
                    if (r_step == LAST_STEP) begin
                        n_state = ST_DONE;
                    end else begin
                        n_step = r_step + CW'(1);
                    end
                end
            end
            ST_DONE: begin
                case (r_req)
                    REQ_TICK: begin
                        if (r_pend_valid) begin
                            w_emit      = 1'b1;
                            w_res.kind  = KIND_EVENT;
                            w_res.pin   = r_pend_pin;
                            w_res.level = r_pend_level;
                            if (w_out_free) begin
                                n_pend_valid = 1'b0;
                                n_state      = ST_IDLE;
                            end
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    REQ_ADD: begin
                        w_emit = 1'b1;
                        if (r_cov) begin
                            w_res.status = STAT_COVERED;
                        end else if (r_count == FULL_CNT) begin
                            w_res.status = STAT_FULL;
                        end else begin
                            w_res.status = STAT_OK;
                        end
                        if (w_out_free) begin
                            n_state = ST_IDLE;
                            if (!r_cov && (r_count != FULL_CNT)) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                    end
                    default: begin
                        w_emit       = 1'b1;
                        w_res.status = r_bad ? STAT_BADIDX : STAT_OK;
                        if (w_out_free) begin
                            n_state = ST_IDLE;
                            if (!r_bad) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_nev        <= '0;
            r_cov        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_step       <= n_step;
            r_nev        <= n_nev;
            r_cov        <= n_cov;
            r_pend_valid <= n_pend_valid;
            if (w_emit && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_pin   <= n_pend_pin;
        r_pend_level <= n_pend_level;
        if (w_emit && w_out_free) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_res.kind;
    assign o_out_pin   = r_res.pin;
    assign o_level     = r_res.level;
    assign o_status    = r_res.status;
    assign o_last      = r_res.last;

    `DWPS_CHECK(a_count_bound, 1'b1, r_count <= FULL_CNT, "Entry count exceeds the table size.")
    `DWPS_CHECK(a_event_bound, 1'b1, r_nev <= EV_LIMIT, "Tick produced too many events.")
    `DWPS_CHECK(a_idle_no_pend, r_state == ST_IDLE, !r_pend_valid, "Event left pending in idle.")
    `DWPS_CHECK_NEXT(a_count_hold, r_state != ST_DONE, $stable(r_count), "Count changed mid-walk.")

endmodule

// ----- hw/rtl/dwps_cell.sv -----
module dwps_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  dwps_pkg::t_entry i_entry,
    output dwps_pkg::t_entry o_entry
);
    import dwps_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ----- hw/rtl/dwps_head.sv -----
module dwps_head (
    input  dwps_pkg::t_entry               i_entry,
    input  logic [dwps_pkg::SECW-1:0]      i_now,
    input  logic [dwps_pkg::MINW-1:0]      i_ns,
    input  logic [dwps_pkg::MINW-1:0]      i_ne,
    input  logic [dwps_pkg::PINW-1:0]      i_pin,
    output dwps_pkg::t_probe               o_probe
);
    import dwps_pkg::*;

    logic [SECW-1:0] w_s;
    logic [SECW-1:0] w_e;

    assign w_s = SECW'(i_entry.start_min) * SECW'(SEC_PER_MIN);
    assign w_e = SECW'(i_entry.end_min) * SECW'(SEC_PER_MIN);

    // A window that wraps past midnight is on from its start or before its end.
    always_comb begin
        if (w_s > w_e) begin
            o_probe.act = (i_now >= w_s) || (i_now < w_e);
        end else begin
            o_probe.act = (i_now >= w_s) && (i_now <= w_e);
        end
        o_probe.cov = (i_entry.pin == i_pin) && (i_ns <= i_entry.start_min)
                      && (i_ne >= i_entry.end_min);
    end

endmodule

// ----- tb/daily_window_pin_scheduler_unit_tb.sv -----
module daily_window_pin_scheduler_unit_tb;
    import dwps_pkg::*;

    localparam logic [REQW-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_CYCLES  = 300;
    localparam int DAY_SECONDS  = 86400;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic [REQW-1:0] req_type;
        logic [SECW-1:0] now_second;
        logic [HRW-1:0]  start_hour;
        logic [MNW-1:0]  start_minute;
        logic [HRW-1:0]  end_hour;
        logic [MNW-1:0]  end_minute;
        logic [PINW-1:0] pin;
        logic [IDXW-1:0] entry_index;
    } t_request;

    class window_scoreboard;
        logic [MINW-1:0] win_start  [MAX_WINDOWS_DEF];
        logic [MINW-1:0] win_end    [MAX_WINDOWS_DEF];
        logic [PINW-1:0] win_pin    [MAX_WINDOWS_DEF];
        logic            win_active [MAX_WINDOWS_DEF];
        int              entry_count;
        t_result         pending_results[$];
        int              errors;

        function new();
            entry_count = 0;
            errors = 0;
        endfunction

        function bit in_window(logic [MINW-1:0] smin, logic [MINW-1:0] emin,
                               int unsigned now);
            int unsigned s;
            int unsigned e;
            s = smin * SEC_PER_MIN;
            e = emin * SEC_PER_MIN;
            if (s > e) begin
                return (now >= s) || (now < e);
            end
            return (s <= now) && (now <= e);
        endfunction

        function t_result status_result(logic [STW-1:0] st);
            t_result res;
            res = '0;
            res.kind = KIND_STATUS;
            res.status = st;
            res.last = 1'b1;
            return res;
        endfunction

        function t_result level_event(logic [PINW-1:0] p, logic lvl);
            t_result res;
            res = '0;
            res.kind = KIND_EVENT;
            res.pin = p;
            res.level = lvl;
            return res;
        endfunction

        function void note_request(t_request r);
            t_result     batch[$];
            int unsigned now;
            int unsigned ns;
            int unsigned ne;
            int          idx;
            bit          covered;
            bit          act;
            now = 32'(r.now_second);
            ns = r.start_hour * MIN_PER_HOUR + r.start_minute;
            ne = r.end_hour * MIN_PER_HOUR + r.end_minute;
            idx = 32'(r.entry_index);
            covered = 1'b0;
            case (r.req_type)
                REQ_TICK: begin
                    for (int i = 0; i < entry_count && batch.size() < MAX_RESULTS; i++) begin
                        act = in_window(win_start[i], win_end[i], now);
                        if (act != win_active[i]) begin
                            win_active[i] = act;
                            batch.push_back(level_event(win_pin[i], act));
                        end
                    end
                    if (batch.size() > 0) begin
                        batch[batch.size() - 1].last = 1'b1;
                    end
                end
                REQ_ADD: begin
                    for (int i = 0; i < entry_count; i++) begin
                        if (win_pin[i] == r.pin && ns <= win_start[i] && ne >= win_end[i]) begin
                            covered = 1'b1;
                        end
                    end
                    if (covered) begin
                        batch.push_back(status_result(STAT_COVERED));
                    end else if (entry_count >= MAX_WINDOWS_DEF) begin
                        batch.push_back(status_result(STAT_FULL));
                    end else begin
                        win_start[entry_count] = ns[MINW-1:0];
                        win_end[entry_count] = ne[MINW-1:0];
                        win_pin[entry_count] = r.pin;
                        win_active[entry_count] = 1'b0;
                        entry_count++;
                        batch.push_back(status_result(STAT_OK));
                    end
                end
                REQ_DEL: begin
                    if (idx >= entry_count) begin
                        batch.push_back(status_result(STAT_BADIDX));
                    end else begin
                        if (win_active[idx]) begin
                            batch.push_back(level_event(win_pin[idx], 1'b0));
                        end
                        for (int i = idx; i + 1 < entry_count; i++) begin
                            win_start[i] = win_start[i + 1];
                            win_end[i] = win_end[i + 1];
                            win_pin[i] = win_pin[i + 1];
                            win_active[i] = win_active[i + 1];
                        end
                        entry_count--;
                        batch.push_back(status_result(STAT_OK));
                    end
                end
                default: begin
                end
            endcase
            foreach (batch[k]) begin
                pending_results.push_back(batch[k]);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d out_pin %0d level %0d status %0d last %0d",
                       got.kind, got.pin, got.level, got.status, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 8'(want.kind), 8'(got.kind));
            compare_field("out_pin", 8'(want.pin), 8'(got.pin));
            compare_field("level", 8'(want.level), 8'(got.level));
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [REQW-1:0] i_req_type;
    logic [SECW-1:0] i_now_second;
    logic [HRW-1:0]  i_start_hour;
    logic [MNW-1:0]  i_start_minute;
    logic [HRW-1:0]  i_end_hour;
    logic [MNW-1:0]  i_end_minute;
    logic [PINW-1:0] i_pin;
    logic [IDXW-1:0] i_entry_index;
    logic            o_out_valid;
    logic            i_out_ready;
    logic            o_kind;
    logic [PINW-1:0] o_out_pin;
    logic            o_level;
    logic [STW-1:0]  o_status;
    logic            o_last;

    window_scoreboard sched = new();
    t_idle_phase      idle_phase = IDLE_NONE;
    int               hold_request = 0;

    daily_window_pin_scheduler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_now_second   (i_now_second),
        .i_start_hour   (i_start_hour),
        .i_start_minute (i_start_minute),
        .i_end_hour     (i_end_hour),
        .i_end_minute   (i_end_minute),
        .i_pin          (i_pin),
        .i_entry_index  (i_entry_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_out_pin      (o_out_pin),
        .o_level        (o_level),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #10;
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
    end

    function automatic int stall_percent(bit sender_side);
        case (idle_phase)
            IDLE_SENDER:   return sender_side ? 48 : 0;
            IDLE_RECEIVER: return sender_side ? 0 : 48;
            IDLE_BOTH:     return 6;
            default:       return 0;
        endcase
    endfunction

    function automatic t_request random_request();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_request)-1:0];
    endfunction

    task automatic send_request(t_request r);
        if ($urandom_range(0, 99) < stall_percent(1'b1)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= r.req_type;
        i_now_second   <= r.now_second;
        i_start_hour   <= r.start_hour;
        i_start_minute <= r.start_minute;
        i_end_hour     <= r.end_hour;
        i_end_minute   <= r.end_minute;
        i_pin          <= r.pin;
        i_entry_index  <= r.entry_index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sched.note_request(r);
    endtask

    task automatic tick_at(int now);
        t_request r;
        r = random_request();
        r.req_type = REQ_TICK;
        r.now_second = SECW'(now);
        send_request(r);
    endtask

    task automatic add_window(int sh, int sm, int eh, int em, int p);
        t_request r;
        r = random_request();
        r.req_type = REQ_ADD;
        r.start_hour = HRW'(sh);
        r.start_minute = MNW'(sm);
        r.end_hour = HRW'(eh);
        r.end_minute = MNW'(em);
        r.pin = PINW'(p);
        send_request(r);
    endtask

    task automatic delete_entry(int idx);
        t_request r;
        r = random_request();
        r.req_type = REQ_DEL;
        r.entry_index = IDXW'(idx);
        send_request(r);
    endtask

    initial begin
        t_result got;
        int      hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = {o_kind, o_out_pin, o_level, o_status, o_last};
                sched.check_result(got);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_percent(1'b0));
            end
        end
    end

    initial begin
        t_request r;
        int       pick;
        int       add_share;
        int       j;
        int       bound;
        int       sent;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_req_type     <= REQ_TICK;
        i_now_second   <= '0;
        i_start_hour   <= '0;
        i_start_minute <= '0;
        i_end_hour     <= '0;
        i_end_minute   <= '0;
        i_pin          <= '0;
        i_entry_index  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tick_at(0);
        delete_entry(0);
        add_window(8, 0, 17, 30, 5);
        add_window(22, 0, 6, 0, 63);
        add_window(0, 0, 0, 0, 0);
        add_window(23, 59, 23, 59, 1);
        add_window(7, 0, 18, 0, 5);
        add_window(8, 0, 17, 30, 5);
        add_window(9, 0, 10, 0, 5);
        r = random_request();
        r.req_type = REQ_UNUSED;
        send_request(r);
        tick_at(0);
        tick_at(8 * 3600);
        tick_at(17 * 3600 + 30 * 60);
        tick_at(17 * 3600 + 30 * 60 + 1);
        add_window(31, 0, 31, 63, 42);
        tick_at(113000);
        tick_at(131071);
        delete_entry(1);
        for (int i = 0; i < 11; i++) begin
            add_window(0, 0, 23, 59, 10 + i);
        end
        add_window(12, 0, 13, 0, 7);
        tick_at(43200);
        delete_entry(15);
        delete_entry(15);
        tick_at(DAY_SECONDS - 1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_phase = t_idle_phase'(sent * 4 / RANDOM_ITEMS);
            if (sent == RANDOM_ITEMS / 8) begin
                hold_request = HOLD_CYCLES;
            end
            r = random_request();
            pick = $urandom_range(0, 99);
            add_share = (sched.entry_count >= 14) ? 15 : (sched.entry_count <= 2 ? 55 : 30);
            if (pick < 35) begin
                r.req_type = REQ_TICK;
                if (sched.entry_count > 0 && $urandom_range(0, 2) == 0) begin
                    j = $urandom_range(0, sched.entry_count - 1);
                    bound = ($urandom_range(0, 1) ? sched.win_start[j] : sched.win_end[j])
                            * SEC_PER_MIN;
                    bound = bound - 1 + int'($urandom_range(0, 2));
                    r.now_second = SECW'((bound < 0) ? 0 : bound);
                end else if ($urandom_range(0, 19) != 0) begin
                    r.now_second = SECW'($urandom_range(0, DAY_SECONDS - 1));
                end else begin
                    r.now_second = SECW'($urandom_range(DAY_SECONDS, (1 << SECW) - 1));
                end
            end else if (pick < 35 + add_share) begin
                r.req_type = REQ_ADD;
                if ($urandom_range(0, 19) != 0) begin
                    r.start_hour = HRW'($urandom_range(0, 23));
                    r.start_minute = MNW'($urandom_range(0, 59));
                    r.end_hour = HRW'($urandom_range(0, 23));
                    r.end_minute = MNW'($urandom_range(0, 59));
                end
                if ($urandom_range(0, 3) != 0) begin
                    r.pin = PINW'($urandom_range(0, 3));
                end
            end else if (pick < 97) begin
                r.req_type = REQ_DEL;
                if (sched.entry_count > 0 && $urandom_range(0, 9) != 0) begin
                    r.entry_index = IDXW'($urandom_range(0, sched.entry_count - 1));
                end
            end else begin
                r.req_type = REQ_UNUSED;
            end
            send_request(r);
            if (r.req_type != REQ_UNUSED) begin
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        idle_phase = IDLE_NONE;
        while (sched.pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * MAX_WINDOWS_DEF) @(posedge i_clk);
        if (sched.errors == 0 && sched.pending_results.size() == 0) begin
            $display("daily_window_pin_scheduler_unit test passed");
        end else begin
            $display("daily_window_pin_scheduler_unit test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("daily_window_pin_scheduler_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dwps_pkg.sv
hw/rtl/dwps_cell.sv
hw/rtl/dwps_head.sv
hw/rtl/daily_window_pin_scheduler_unit.sv
tb/daily_window_pin_scheduler_unit_tb.sv
